>>> src/rtc_pkg.sv
// Shared types, widths and codes for the ray/triangle closest-hit core.
`default_nettype none
package rtc_pkg;

	// Field and datapath widths
	localparam int COORD_W  = 32;
	localparam int MESH_W   = 8;
	localparam int BEST_W   = 9;
	localparam int DIFF_W   = COORD_W + 1;        // edge and offset vectors
	localparam int CROSS_W  = 2 * DIFF_W + 1;     // cross product components
	localparam int ACC_W    = DIFF_W + CROSS_W + 2; // dot products with margin
	localparam int NUM_W    = ACC_W + COORD_W + 1;  // divider numerator and divisor
	localparam int QUO_W    = 32;
	localparam int CNT_W    = 6;
	localparam int OP_W     = 5;
	localparam logic [OP_W-1:0] OP_LAST = OP_W'(23);

	localparam logic [BEST_W-1:0] MESH_NONE = '1;
	localparam logic [QUO_W-1:0]  T_NONE    = '1;

	// Register map
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int NUM_REGS = 7;
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X    = 3'd3;
	localparam logic [2:0] REG_DIR_Y    = 3'd4;
	localparam logic [2:0] REG_DIR_Z    = 3'd5;
	localparam logic [2:0] REG_DET_EPS  = 3'd6;
	localparam logic [DATA_W-1:0] DIR_Z_RESET = 32'hFFFF_0000;

	// Queue between front and back
	localparam int Q_DEPTH = 2;                   // power of two
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef logic [2:0][COORD_W-1:0] coord3_t;
	typedef logic [2:0][DIFF_W-1:0]  diff3_t;

	typedef struct packed {
		coord3_t             origin;
		coord3_t             dir;
		logic [DATA_W-1:0]   det_eps;
	} ray_cfg_t;

	typedef struct packed {
		diff3_t              e1;
		diff3_t              e2;
		diff3_t              s;
		logic [MESH_W-1:0]   mesh;
		logic                mesh_ok;
		logic                last;
	} item_t;

	// Multiply-accumulate microcode
	typedef enum logic [1:0] { AV_E1, AV_E2, AV_S, AV_DIR } avec_t;
	typedef enum logic [1:0] { BV_DIR, BV_S, BV_H, BV_Q } bvec_t;
	typedef enum logic [2:0] { DST_H, DST_Q, DST_D, DST_U, DST_V, DST_T } dst_t;

	typedef struct packed {
		avec_t       av;
		logic [1:0]  ac;
		bvec_t       bv;
		logic [1:0]  bc;
		logic        neg;
		logic        first;
		logic        last;
		dst_t        dst;
		logic [1:0]  dc;
	} uop_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_LOAD, BK_MUL, BK_NORM, BK_CMP, BK_SAT, BK_DIV, BK_DONE
	} back_state_t;

	function automatic uop_t mk_uop(avec_t av, logic [1:0] ac, bvec_t bv, logic [1:0] bc,
			logic neg, logic first, logic last, dst_t dst, logic [1:0] dc);
		uop_t u;
		u.av = av; u.ac = ac; u.bv = bv; u.bc = bc;
		u.neg = neg; u.first = first; u.last = last;
		u.dst = dst; u.dc = dc;
		return u;
	endfunction

	// H = dir x E2, Q = S x E1, then D = E1.H, U = S.H, V = dir.Q, T = E2.Q
	function automatic uop_t uop_of(logic [OP_W-1:0] op);
		uop_t u;
		unique case (op)
			5'd0:  u = mk_uop(AV_E2, 2'd2, BV_DIR, 2'd1, 1'b0, 1'b1, 1'b0, DST_H, 2'd0);
			5'd1:  u = mk_uop(AV_E2, 2'd1, BV_DIR, 2'd2, 1'b1, 1'b0, 1'b1, DST_H, 2'd0);
			5'd2:  u = mk_uop(AV_E2, 2'd0, BV_DIR, 2'd2, 1'b0, 1'b1, 1'b0, DST_H, 2'd1);
			5'd3:  u = mk_uop(AV_E2, 2'd2, BV_DIR, 2'd0, 1'b1, 1'b0, 1'b1, DST_H, 2'd1);
			5'd4:  u = mk_uop(AV_E2, 2'd1, BV_DIR, 2'd0, 1'b0, 1'b1, 1'b0, DST_H, 2'd2);
			5'd5:  u = mk_uop(AV_E2, 2'd0, BV_DIR, 2'd1, 1'b1, 1'b0, 1'b1, DST_H, 2'd2);
			5'd6:  u = mk_uop(AV_E1, 2'd2, BV_S,   2'd1, 1'b0, 1'b1, 1'b0, DST_Q, 2'd0);
			5'd7:  u = mk_uop(AV_E1, 2'd1, BV_S,   2'd2, 1'b1, 1'b0, 1'b1, DST_Q, 2'd0);
			5'd8:  u = mk_uop(AV_E1, 2'd0, BV_S,   2'd2, 1'b0, 1'b1, 1'b0, DST_Q, 2'd1);
			5'd9:  u = mk_uop(AV_E1, 2'd2, BV_S,   2'd0, 1'b1, 1'b0, 1'b1, DST_Q, 2'd1);
			5'd10: u = mk_uop(AV_E1, 2'd1, BV_S,   2'd0, 1'b0, 1'b1, 1'b0, DST_Q, 2'd2);
			5'd11: u = mk_uop(AV_E1, 2'd0, BV_S,   2'd1, 1'b1, 1'b0, 1'b1, DST_Q, 2'd2);
			5'd12: u = mk_uop(AV_E1, 2'd0, BV_H,   2'd0, 1'b0, 1'b1, 1'b0, DST_D, 2'd0);
			5'd13: u = mk_uop(AV_E1, 2'd1, BV_H,   2'd1, 1'b0, 1'b0, 1'b0, DST_D, 2'd0);
			5'd14: u = mk_uop(AV_E1, 2'd2, BV_H,   2'd2, 1'b0, 1'b0, 1'b1, DST_D, 2'd0);
			5'd15: u = mk_uop(AV_S,  2'd0, BV_H,   2'd0, 1'b0, 1'b1, 1'b0, DST_U, 2'd0);
			5'd16: u = mk_uop(AV_S,  2'd1, BV_H,   2'd1, 1'b0, 1'b0, 1'b0, DST_U, 2'd0);
			5'd17: u = mk_uop(AV_S,  2'd2, BV_H,   2'd2, 1'b0, 1'b0, 1'b1, DST_U, 2'd0);
			5'd18: u = mk_uop(AV_DIR, 2'd0, BV_Q,  2'd0, 1'b0, 1'b1, 1'b0, DST_V, 2'd0);
			5'd19: u = mk_uop(AV_DIR, 2'd1, BV_Q,  2'd1, 1'b0, 1'b0, 1'b0, DST_V, 2'd0);
			5'd20: u = mk_uop(AV_DIR, 2'd2, BV_Q,  2'd2, 1'b0, 1'b0, 1'b1, DST_V, 2'd0);
			5'd21: u = mk_uop(AV_E2, 2'd0, BV_Q,   2'd0, 1'b0, 1'b1, 1'b0, DST_T, 2'd0);
			5'd22: u = mk_uop(AV_E2, 2'd1, BV_Q,   2'd1, 1'b0, 1'b0, 1'b0, DST_T, 2'd0);
			default: u = mk_uop(AV_E2, 2'd2, BV_Q, 2'd2, 1'b0, 1'b0, 1'b1, DST_T, 2'd0);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

>>> src/rtc_tri_if.sv
// Triangle request channel: three vertices, mesh index and last flag.
`default_nettype none
interface rtc_tri_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  a_x;
	logic signed [31:0]  a_y;
	logic signed [31:0]  a_z;
	logic signed [31:0]  b_x;
	logic signed [31:0]  b_y;
	logic signed [31:0]  b_z;
	logic signed [31:0]  c_x;
	logic signed [31:0]  c_y;
	logic signed [31:0]  c_z;
	logic [7:0]          mesh_id;
	logic                last_tri;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		mesh_id, last_tri, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		mesh_id, last_tri, output ready);
endinterface
`default_nettype wire

>>> src/rtc_hit_if.sv
// Hit result channel: per-triangle hit and the running closest hit.
`default_nettype none
interface rtc_hit_if;
	logic                valid;
	logic                ready;
	logic                hit;
	logic [31:0]         hit_t;
	logic signed [8:0]   best_mesh;
	logic [31:0]         best_t;
	logic                pick_done;

	modport source (output valid, hit, hit_t, best_mesh, best_t, pick_done, input ready);
	modport sink (input valid, hit, hit_t, best_mesh, best_t, pick_done, output ready);
endinterface
`default_nettype wire

>>> src/rtc_front.sv
// Front end: accepts triangles, forms edge and offset vectors, checks the mesh range.
`default_nettype none
module rtc_front import rtc_pkg::*; #(
	parameter int MAX_MESHES = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ray_cfg_t cfg,
	rtc_tri_if.sink    tri_req,
	output item_t      push_item,
	output logic       push_valid,
	input  wire logic  push_ready
);

	item_t item_s1;
	logic  valid_s1;
	logic  take;

	function automatic logic [DIFF_W-1:0] diff(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		return {x[COORD_W-1], x} - {y[COORD_W-1], y};
	endfunction

	assign tri_req.ready = !valid_s1 || push_ready;
	assign take          = tri_req.valid && tri_req.ready;
	assign push_valid    = valid_s1;
	assign push_item     = item_s1;

	// Hold the stage valid until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Form E1 = B - A, E2 = C - A, S = origin - A; flag meshes out of range
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.e1[0] <= diff(tri_req.b_x, tri_req.a_x);
			item_s1.e1[1] <= diff(tri_req.b_y, tri_req.a_y);
			item_s1.e1[2] <= diff(tri_req.b_z, tri_req.a_z);
			item_s1.e2[0] <= diff(tri_req.c_x, tri_req.a_x);
			item_s1.e2[1] <= diff(tri_req.c_y, tri_req.a_y);
			item_s1.e2[2] <= diff(tri_req.c_z, tri_req.a_z);
			item_s1.s[0]  <= diff(cfg.origin[0], tri_req.a_x);
			item_s1.s[1]  <= diff(cfg.origin[1], tri_req.a_y);
			item_s1.s[2]  <= diff(cfg.origin[2], tri_req.a_z);
			item_s1.mesh    <= tri_req.mesh_id;
			item_s1.mesh_ok <= {{(32-MESH_W){1'b0}}, tri_req.mesh_id} < 32'(MAX_MESHES);
			item_s1.last    <= tri_req.last_tri;
		end
	end

endmodule
`default_nettype wire

>>> src/rtc_queue.sv
// Short request queue between the front end and the arithmetic back end.
`default_nettype none
module rtc_queue import rtc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t push_item,
	input  wire logic  push_valid,
	output logic       push_ready,
	output item_t      pop_item,
	output logic       pop_valid,
	input  wire logic  pop_ready
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_PTR_W:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != (Q_PTR_W+1)'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + Q_PTR_W'(1);
			if (do_pop)  rd_q <= rd_q + Q_PTR_W'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + (Q_PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (Q_PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

>>> src/rtc_back.sv
// Back end: serial multiply-accumulate, hit test, serial divide and closest-hit tracker.
`default_nettype none
module rtc_back import rtc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ray_cfg_t cfg,
	input  wire item_t    pop_item,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	rtc_hit_if.source     hit_rsp
);

	back_state_t state_q, state_d;

	item_t                      item_q;
	logic [OP_W-1:0]            op_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    mcand_q;
	logic [DIFF_W-1:0]          mplier_q;
	logic signed [CROSS_W-1:0]  h_q [3];
	logic signed [CROSS_W-1:0]  qv_q [3];
	logic signed [ACC_W-1:0]    d_q, u_q, v_q, t_q;
	logic [NUM_W-1:0]           nrem_q, dsh_q;
	logic [QUO_W-1:0]           quo_q;
	logic                       hit_q;

	logic [QUO_W-1:0]           cl_t_q;
	logic [BEST_W-1:0]          cl_mesh_q;
	logic                       out_valid_q;
	logic                       out_hit_q, out_done_q;
	logic [QUO_W-1:0]           out_hit_t_q, out_best_t_q;
	logic [BEST_W-1:0]          out_best_mesh_q;

	uop_t                       uop;
	logic [DIFF_W-1:0]          a_op;
	logic signed [ACC_W-1:0]    b_op;
	logic signed [ACC_W-1:0]    acc_step;
	logic                       sub;
	logic                       mul_last;
	logic signed [ACC_W-1:0]    eps_bound;
	logic signed [ACC_W-1:0]    uv_sum;
	logic                       pass;
	logic                       sat;
	logic                       div_ge;
	logic                       out_free;
	logic                       fire;
	logic [QUO_W-1:0]           hit_t_val;
	logic                       take_best;
	logic [QUO_W-1:0]           best_t_new;
	logic [BEST_W-1:0]          best_mesh_new;

	function automatic logic [DIFF_W-1:0] pick_d(diff3_t v, logic [1:0] i);
		case (i)
			2'd0:    return v[0];
			2'd1:    return v[1];
			default: return v[2];
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_c(coord3_t v, logic [1:0] i);
		case (i)
			2'd0:    return v[0];
			2'd1:    return v[1];
			default: return v[2];
		endcase
	endfunction

	function automatic logic [ACC_W-1:0] sext_c(logic [CROSS_W-1:0] x);
		return {{(ACC_W-CROSS_W){x[CROSS_W-1]}}, x};
	endfunction

	// Select multiplier and multiplicand for the current micro-op
	assign uop = uop_of(op_q);

	always_comb begin
		logic [COORD_W-1:0] dv;
		dv = pick_c(cfg.dir, uop.ac);
		unique case (uop.av)
			AV_E1:   a_op = pick_d(item_q.e1, uop.ac);
			AV_E2:   a_op = pick_d(item_q.e2, uop.ac);
			AV_S:    a_op = pick_d(item_q.s, uop.ac);
			default: a_op = {dv[COORD_W-1], dv};
		endcase
	end

	always_comb begin
		logic [COORD_W-1:0] dv;
		logic [DIFF_W-1:0]  sv;
		dv = pick_c(cfg.dir, uop.bc);
		sv = pick_d(item_q.s, uop.bc);
		unique case (uop.bv)
			BV_DIR:  b_op = {{(ACC_W-COORD_W){dv[COORD_W-1]}}, dv};
			BV_S:    b_op = {{(ACC_W-DIFF_W){sv[DIFF_W-1]}}, sv};
			BV_H: begin
				case (uop.bc)
					2'd0:    b_op = sext_c(h_q[0]);
					2'd1:    b_op = sext_c(h_q[1]);
					default: b_op = sext_c(h_q[2]);
				endcase
			end
			default: begin
				case (uop.bc)
					2'd0:    b_op = sext_c(qv_q[0]);
					2'd1:    b_op = sext_c(qv_q[1]);
					default: b_op = sext_c(qv_q[2]);
				endcase
			end
		endcase
	end

	// One shift-add step; the multiplier's top bit carries negative weight
	assign mul_last = cnt_q == CNT_W'(DIFF_W - 1);
	assign sub      = uop.neg ^ mul_last;
	assign acc_step = !mplier_q[0] ? acc_q : (sub ? acc_q - mcand_q : acc_q + mcand_q);

	// Hit test on the sign-normalized values
	assign eps_bound = {{(ACC_W-DATA_W){1'b0}}, cfg.det_eps} << (2 * FRAC_BITS);
	assign uv_sum    = u_q + v_q;
	assign pass      = (d_q > eps_bound) && !u_q[ACC_W-1] && (u_q <= d_q) &&
		!v_q[ACC_W-1] && (uv_sum <= d_q) && !t_q[ACC_W-1] && (t_q != '0);
	assign sat       = nrem_q >= (dsh_q << 1);
	assign div_ge    = nrem_q >= dsh_q;

	assign out_free  = !out_valid_q || hit_rsp.ready;
	assign pop_ready = state_q == BK_IDLE;
	assign fire      = (state_q == BK_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one triangle through the shared units
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) state_d = pop_item.mesh_ok ? BK_LOAD : BK_DONE;
			end
			BK_LOAD: state_d = BK_MUL;
			BK_MUL: begin
				if (mul_last) state_d = (op_q == OP_LAST) ? BK_NORM : BK_LOAD;
			end
			BK_NORM: state_d = BK_CMP;
			BK_CMP:  state_d = pass ? BK_SAT : BK_DONE;
			BK_SAT:  state_d = sat ? BK_DONE : BK_DIV;
			BK_DIV: begin
				if (cnt_q == CNT_W'(QUO_W - 1)) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					item_q <= pop_item;
					op_q   <= '0;
					hit_q  <= 1'b0;
					quo_q  <= '0;
				end
			end
			BK_LOAD: begin
				mplier_q <= a_op;
				mcand_q  <= b_op;
				cnt_q    <= '0;
				if (uop.first) acc_q <= '0;
			end
			BK_MUL: begin
				acc_q    <= acc_step;
				mplier_q <= mplier_q >> 1;
				mcand_q  <= mcand_q <<< 1;
				cnt_q    <= cnt_q + CNT_W'(1);
				if (mul_last) begin
					op_q <= op_q + OP_W'(1);
					if (uop.last) begin
						case (uop.dst)
							DST_H: begin
								case (uop.dc)
									2'd0:    h_q[0] <= acc_step[CROSS_W-1:0];
									2'd1:    h_q[1] <= acc_step[CROSS_W-1:0];
									default: h_q[2] <= acc_step[CROSS_W-1:0];
								endcase
							end
							DST_Q: begin
								case (uop.dc)
									2'd0:    qv_q[0] <= acc_step[CROSS_W-1:0];
									2'd1:    qv_q[1] <= acc_step[CROSS_W-1:0];
									default: qv_q[2] <= acc_step[CROSS_W-1:0];
								endcase
							end
							DST_D:   d_q <= acc_step;
							DST_U:   u_q <= acc_step;
							DST_V:   v_q <= acc_step;
							default: t_q <= acc_step;
						endcase
					end
				end
			end
			BK_NORM: begin
				if (d_q[ACC_W-1]) begin
					d_q <= -d_q;
					u_q <= -u_q;
					v_q <= -v_q;
					t_q <= -t_q;
				end
			end
			BK_CMP: begin
				hit_q  <= pass;
				nrem_q <= {{(NUM_W-ACC_W){1'b0}}, t_q} << FRAC_BITS;
				dsh_q  <= {{(NUM_W-ACC_W){1'b0}}, d_q} << (QUO_W - 1);
				cnt_q  <= '0;
			end
			BK_SAT: begin
				if (sat) quo_q <= T_NONE;
			end
			BK_DIV: begin
				if (div_ge) nrem_q <= nrem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Closest-hit update; ties keep the earlier hit
	assign hit_t_val     = hit_q ? quo_q : '0;
	assign take_best     = hit_q && ((cl_mesh_q == MESH_NONE) || (hit_t_val < cl_t_q));
	assign best_t_new    = take_best ? hit_t_val : cl_t_q;
	assign best_mesh_new = take_best ? {1'b0, item_q.mesh} : cl_mesh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cl_t_q      <= T_NONE;
			cl_mesh_q   <= MESH_NONE;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (hit_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				cl_t_q    <= item_q.last ? T_NONE : best_t_new;
				cl_mesh_q <= item_q.last ? MESH_NONE : best_mesh_new;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (fire) begin
			out_hit_q       <= hit_q;
			out_hit_t_q     <= hit_t_val;
			out_best_mesh_q <= best_mesh_new;
			out_best_t_q    <= best_t_new;
			out_done_q      <= item_q.last;
		end
	end

	assign hit_rsp.valid     = out_valid_q;
	assign hit_rsp.hit       = out_hit_q;
	assign hit_rsp.hit_t     = out_hit_t_q;
	assign hit_rsp.best_mesh = out_best_mesh_q;
	assign hit_rsp.best_t    = out_best_t_q;
	assign hit_rsp.pick_done = out_done_q;

endmodule
`default_nettype wire

>>> src/ray_triangle_closest_hit_core.sv
// Top level of the ray/triangle closest-hit core: register port, front, queue and back.
`default_nettype none
// Tests a stream of triangles against one ray held in registers (origin, direction and a
// determinant threshold, all signed Q16.16 but the threshold) and reports per triangle
// whether it is hit, the hit distance, and the closest hit of the pick so far; the
// triangle with the last flag closes the pick and clears the tracker. The front end
// takes a triangle per cycle, while the queue has room, into a two-entry queue. The back
// end handles one triangle at a time on a single serial multiply-accumulate unit that
// works one multiplier bit per cycle: 24 products, each a load and one shift-add per
// multiplier bit, then sign fixup and test, and for a hit a saturation check plus, unless
// the distance saturates, a restoring divide to a 32-bit quotient, then the result
// handshake. Triangles with an out-of-range mesh index skip to the handshake; a stalled
// result receiver holds the back end in its last state. The user must write registers
// over the APB-style port only while no triangle is in flight; the block does not check.
module ray_triangle_closest_hit_core import rtc_pkg::*; #(
	parameter int MAX_MESHES = 256,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	rtc_tri_if.sink                tri_req,
	rtc_hit_if.source              hit_rsp
);

	logic [DATA_W-1:0] cfg_q [NUM_REGS];
	logic [2:0]        reg_idx;
	logic              reg_hit;
	ray_cfg_t          cfg;
	item_t             push_item, pop_item;
	logic              push_valid, push_ready, pop_valid, pop_ready;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_hit = 32'(reg_idx) < NUM_REGS;

	// Register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
			cfg_q[REG_DIR_Z] <= DIR_Z_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			cfg_q[reg_idx] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) prdata = cfg_q[reg_idx];
	end

	assign cfg.origin[0] = cfg_q[REG_ORIGIN_X];
	assign cfg.origin[1] = cfg_q[REG_ORIGIN_Y];
	assign cfg.origin[2] = cfg_q[REG_ORIGIN_Z];
	assign cfg.dir[0]    = cfg_q[REG_DIR_X];
	assign cfg.dir[1]    = cfg_q[REG_DIR_Y];
	assign cfg.dir[2]    = cfg_q[REG_DIR_Z];
	assign cfg.det_eps   = cfg_q[REG_DET_EPS];

	rtc_front #(
		.MAX_MESHES(MAX_MESHES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.tri_req(tri_req),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	rtc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_item(pop_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready)
	);

	rtc_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pop_item(pop_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.hit_rsp(hit_rsp)
	);

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the ray/triangle closest-hit core.
`timescale 1ns / 1ps
module tb_top;
	import rtc_pkg::*;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [31:0] v [9];  // a_x..c_z
		logic [7:0]         mesh;
		logic               last;
	} tri_req_t;

	typedef struct {
		logic        hit;
		logic [31:0] hit_t;
		logic [8:0]  best_mesh;
		logic [31:0] best_t;
		logic        pick_done;
	} hit_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	rtc_tri_if tri_ch ();
	rtc_hit_if hit_ch ();

	ray_triangle_closest_hit_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.tri_req(tri_ch.sink), .hit_rsp(hit_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the ray registers and the closest-hit tracker
	logic signed [31:0] ray_org [3];
	logic signed [31:0] ray_dir [3];
	logic [31:0]        ray_eps;
	logic [31:0]        near_t;
	logic [8:0]         near_mesh;

	tri_req_t pending_tris [$];
	hit_rsp_t expected_hits [$];
	tri_req_t on_bus;

	int errors = 0;
	int n_sent = 0, n_results = 0, n_hits = 0, n_picks = 0, n_phases = 0;
	longint cycles = 0;
	int hold_cycles = 0;
	bit hold_armed = 1'b0;

	// Exact Moller-Trumbore test plus closest-hit update
	function automatic hit_rsp_t trace_triangle(tri_req_t tr);
		wide_t a [3], e1 [3], e2 [3], s [3], h [3], q [3], dv [3];
		wide_t d, u, v, t, eps, num;
		hit_rsp_t r;
		for (int i = 0; i < 3; i++) begin
			a[i]  = tr.v[i];
			e1[i] = wide_t'(tr.v[3+i]) - a[i];
			e2[i] = wide_t'(tr.v[6+i]) - a[i];
			s[i]  = wide_t'(ray_org[i]) - a[i];
			dv[i] = ray_dir[i];
		end
		h[0] = dv[1]*e2[2] - dv[2]*e2[1];
		h[1] = dv[2]*e2[0] - dv[0]*e2[2];
		h[2] = dv[0]*e2[1] - dv[1]*e2[0];
		q[0] = s[1]*e1[2] - s[2]*e1[1];
		q[1] = s[2]*e1[0] - s[0]*e1[2];
		q[2] = s[0]*e1[1] - s[1]*e1[0];
		d = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
		u = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
		v = dv[0]*q[0] + dv[1]*q[1] + dv[2]*q[2];
		t = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
		if (d < 0) begin
			d = -d; u = -u; v = -v; t = -t;
		end
		eps = wide_t'({1'b0, ray_eps}) <<< 32;
		r.hit = 1'b0;
		r.hit_t = '0;
		if (d > eps && u >= 0 && u <= d && v >= 0 && u + v <= d && t > 0) begin
			r.hit = 1'b1;
			num = t <<< 16;
			if (num >= (d <<< 32))
				r.hit_t = '1;
			else
				r.hit_t = 32'(num / d);
		end
		if (r.hit && (near_mesh == MESH_NONE || r.hit_t < near_t)) begin
			near_t = r.hit_t;
			near_mesh = {1'b0, tr.mesh};
		end
		r.best_mesh = near_mesh;
		r.best_t = near_t;
		r.pick_done = tr.last;
		if (tr.last) begin
			near_t = T_NONE;
			near_mesh = MESH_NONE;
		end
		return r;
	endfunction

	// Sender: offer pending triangles with random gaps
	int gap = 0, calm = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_ch.valid <= 1'b0;
			tri_ch.a_x <= '0; tri_ch.a_y <= '0; tri_ch.a_z <= '0;
			tri_ch.b_x <= '0; tri_ch.b_y <= '0; tri_ch.b_z <= '0;
			tri_ch.c_x <= '0; tri_ch.c_y <= '0; tri_ch.c_z <= '0;
			tri_ch.mesh_id <= '0; tri_ch.last_tri <= 1'b0;
		end else begin
			if (tri_ch.valid && tri_ch.ready) begin
				expected_hits.insert(expected_hits.size(), trace_triangle(on_bus));
				n_sent++;
			end
			if (!tri_ch.valid || tri_ch.ready) begin
				if (gap > 0) begin
					tri_ch.valid <= 1'b0;
					gap = gap - 1;
				end else if (pending_tris.size() > 0) begin
					on_bus = pending_tris.pop_front();
					tri_ch.a_x <= on_bus.v[0]; tri_ch.a_y <= on_bus.v[1];
					tri_ch.a_z <= on_bus.v[2]; tri_ch.b_x <= on_bus.v[3];
					tri_ch.b_y <= on_bus.v[4]; tri_ch.b_z <= on_bus.v[5];
					tri_ch.c_x <= on_bus.v[6]; tri_ch.c_y <= on_bus.v[7];
					tri_ch.c_z <= on_bus.v[8];
					tri_ch.mesh_id <= on_bus.mesh;
					tri_ch.last_tri <= on_bus.last;
					tri_ch.valid <= 1'b1;
					if (calm > 0) begin
						calm--;
						gap = 0;
					end else if ($urandom_range(0, 19) == 0) begin
						calm = $urandom_range(5, 20);
						gap = 0;
					end else if ($urandom_range(0, 9) == 0)
						gap = $urandom_range(50, 300);
					else
						gap = $urandom_range(0, 3);
				end else
					tri_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, one long hold so the input backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_ch.ready <= 1'b0;
		end else begin
			if (hold_armed && n_sent >= 40) begin
				hold_armed = 1'b0;
				hold_cycles = 6000;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				hit_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 49) == 0)
				hold_cycles = $urandom_range(100, 900);
			else
				hit_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && hit_ch.valid && hit_ch.ready) begin
			hit_rsp_t e;
			if (expected_hits.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				e = expected_hits.pop_front();
				n_results++;
				if (e.hit) n_hits++;
				if (e.pick_done) n_picks++;
				if (hit_ch.hit !== e.hit || hit_ch.hit_t !== e.hit_t ||
						hit_ch.best_mesh !== e.best_mesh || hit_ch.best_t !== e.best_t ||
						hit_ch.pick_done !== e.pick_done) begin
					errors++;
					if (errors <= 10)
						$display("mismatch result %0d: exp hit=%b t=%h best=%h/%h done=%b, got hit=%b t=%h best=%h/%h done=%b",
							n_results, e.hit, e.hit_t, e.best_mesh, e.best_t, e.pick_done,
							hit_ch.hit, hit_ch.hit_t, hit_ch.best_mesh, hit_ch.best_t,
							hit_ch.pick_done);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 20_000_000) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx <= REG_ORIGIN_Z) ray_org[idx] = val;
		else if (idx <= REG_DIR_Z) ray_dir[idx - 3] = val;
		else ray_eps = val;
	endtask

	task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, eps);
		write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy); write_reg(REG_DIR_Z, dz);
		write_reg(REG_DET_EPS, eps);
	endtask

	task automatic push_tri(input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz,
			input logic [7:0] mesh, input logic last);
		tri_req_t tr;
		tr.v[0] = ax; tr.v[1] = ay; tr.v[2] = az;
		tr.v[3] = bx; tr.v[4] = by; tr.v[5] = bz;
		tr.v[6] = cx; tr.v[7] = cy; tr.v[8] = cz;
		tr.mesh = mesh; tr.last = last;
		pending_tris.insert(pending_tris.size(), tr);
	endtask

	// Triangle facing the z axis at depth z, spanning +-r around (0,0)
	task automatic push_flat(input logic [31:0] z, r, input logic [7:0] mesh,
			input logic last);
		push_tri(-r, -r, z, r, -r, z, 32'sd0, r, z, mesh, last);
	endtask

	// Triangle around a point on the ray, or pure noise now and then
	task automatic push_random_tri(input bit last);
		longint sc, ctr [3];
		int r;
		logic [31:0] w [9];
		if ($urandom_range(0, 9) < 3) begin
			for (int i = 0; i < 9; i++) w[i] = $urandom;
		end else begin
			sc = longint'($urandom_range(0, 22 * 65536)) - 2 * 65536;
			for (int i = 0; i < 3; i++)
				ctr[i] = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * sc) >>> 16);
			r = 1 << $urandom_range(4, 24);
			for (int i = 0; i < 9; i++)
				w[i] = 32'(ctr[i % 3] + longint'($urandom_range(0, 2 * r)) - r);
		end
		push_tri(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8],
			8'($urandom), last);
	endtask

	task automatic drain();
		while (pending_tris.size() > 0 || tri_ch.valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		n_phases++;
	endtask

	function automatic logic [31:0] rand_small();
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
	endfunction

	initial begin
		ray_org = '{default: '0};
		ray_dir = '{0, 0, DIR_Z_RESET};
		ray_eps = '0;
		near_t = T_NONE;
		near_mesh = MESH_NONE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset ray: plain hits, misses, behind, degenerate, ties, extremes
		hold_armed = 1'b1;
		push_flat(-32'sd5 <<< 16, 32'sd1 <<< 16, 8'd3, 1'b0);
		push_flat(-32'sd2 <<< 16, 32'sd1 <<< 16, 8'd7, 1'b0);
		push_flat(-32'sd2 <<< 16, 32'sd1 <<< 16, 8'd9, 1'b0);   // tie keeps mesh 7
		push_flat(32'sd3 <<< 16, 32'sd1 <<< 16, 8'd1, 1'b0);    // behind origin
		push_flat(-32'sd1, 32'sd1 <<< 16, 8'd255, 1'b1);        // t of one LSB
		push_tri(0, 0, -65536, 65536, 0, -65536, 0, 65536, -65536, 8'd0, 1'b0); // vertex on ray
		push_tri(65536, 65536, -65536, 131072, 65536, -65536, 65536, 131072, -65536,
			8'd4, 1'b0);                                          // miss beside
		push_tri(0, 0, -65536, 65536, 0, -65536, 131072, 0, -65536, 8'd5, 1'b0); // collinear
		push_tri('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
			'1 >> 1, 8'hFF, 1'b0);
		push_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 1'b0);
		push_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'h55, 1'b1);
		push_flat(32'h8000_0000, 32'h7FFF_FFFF, 8'hAA, 1'b1);
		drain();

		// Steep direction: distance below one unit
		set_ray(0, 0, 0, 0, 0, 32'h8000_0000, 0);
		push_flat(-32'sd1, 32'sd1 <<< 16, 8'd12, 1'b0);
		push_flat(-32'sd100 <<< 16, 32'sd1 <<< 16, 8'd13, 1'b1);
		drain();
		// Tiny direction: saturated distance
		set_ray(0, 0, 0, 0, 0, -32'sd1, 0);
		push_flat(-32'sd30000 <<< 16, 32'sd1 <<< 16, 8'd20, 1'b0);
		push_flat(-32'sd30001 <<< 16, 32'sd1 <<< 16, 8'd21, 1'b1);
		drain();
		// Zero direction, then largest epsilon
		set_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
		push_flat(-32'sd5 <<< 16, 32'sd1 <<< 16, 8'd2, 1'b1);
		drain();
		set_ray(0, 0, 0, 0, 0, -32'sd65536, '1);
		push_flat(-32'sd5 <<< 16, 32'h7FFF_FFFF, 8'd2, 1'b1);
		drain();

		// Random rays, mostly small values, with extremes in a few phases
		for (int ph = 0; ph < 8; ph++) begin
			set_ray(rand_small(), rand_small(), rand_small(),
				rand_small(), rand_small(), rand_small(),
				(ph == 3) ? '1 : (ph == 5) ? 32'($urandom_range(0, 1 << 12)) : 32'd0);
			if (ph == 6) set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
			for (int k = 0; k < 178; k++)
				push_random_tri($urandom_range(0, 5) == 0 || k == 177);
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Covered %0d triangles in %0d ray settings: %0d hits, %0d picks closed.",
			n_sent, n_phases, n_hits, n_picks);
		if (errors == 0 && expected_hits.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

>>> sim.f
src/rtc_pkg.sv
src/rtc_tri_if.sv
src/rtc_hit_if.sv
src/rtc_front.sv
src/rtc_queue.sv
src/rtc_back.sv
src/ray_triangle_closest_hit_core.sv
sim/tb_top.sv
